// File: hw/rtl/mpf_pkg.sv
// Shared types and constants for the multilevel priority FIFO.
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_BAD_PRI = 2'd3
  } status_e;

  // Reset value of the active level count register.
  localparam logic [3:0] ACT_LEVELS_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] task_id;
    logic [3:0]  priority_req;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        head_valid;
    logic [15:0] head_task;
    logic [3:0]  head_priority;
    logic [7:0]  total_count;
    logic [4:0]  level_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/mpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire                                      clk_i,
  input  wire                                      we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                         wdata_i,
  input  wire                                      re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/multilevel_priority_fifo_core.sv
// Top level of the multilevel strict priority FIFO of task identifiers.
//
// Usage:
//  - Command channel: an item (mode, task_id, priority_req) is a transaction
//    when start is high and busy is low. busy never rises, so one item can be
//    issued every cycle.
//  - Result channel: done_o pulses for one cycle with result_o; the receiver
//    cannot stall it. An accepted item goes through the input register, then
//    one pass of logic into the result register.
//  - Throughput: 1 item per cycle. Each level keeps its head and the entry
//    behind it in flops; the RAM (one write, one registered read port) is
//    only read to refill the second entry after a pop, and that read lands
//    in time for a pop of the same level in the very next cycle.
//  - Config channel: cfg_valid_i/cfg_ready_o write active_levels; only write
//    while no transaction is in flight. Lowering it hides upper levels
//    without discarding their tasks.
//  - Reset: all levels empty, active_levels = 8. The task store is not
//    cleared; fill counts keep every read on a written entry, so there is
//    no clearing pass and the block is usable right after reset.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_fifo_core #(
  parameter int LEVELS      = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire mpf_pkg::item_t item_i,
  output logic               done_o,
  output mpf_pkg::result_t   result_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [3:0]         cfg_data_i
);

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int FW    = $clog2(LEVEL_DEPTH + 1);
  localparam int DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW  = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l,
                                            input logic [PW-1:0] p);
    addr_of = AW'(AW'(l) * AW'(LEVEL_DEPTH) + AW'(p));
  endfunction

  // Config register
  logic [3:0] act_q;

  // Input register
  logic           in_vld_q;
  mpf_pkg::item_t in_q;

  // Per-level queue state
  logic [PW-1:0]      head_ptr_q [LEVELS];
  logic [PW-1:0]      head_ptr_d [LEVELS];
  logic [PW-1:0]      tail_ptr_q [LEVELS];
  logic [PW-1:0]      tail_ptr_d [LEVELS];
  logic [FW-1:0]      fill_q     [LEVELS];
  logic [FW-1:0]      fill_d     [LEVELS];
  logic [ID_BITS-1:0] head_q     [LEVELS];  // entry at head pointer
  logic [ID_BITS-1:0] head_d     [LEVELS];
  logic [ID_BITS-1:0] nxt_q      [LEVELS];  // entry behind the head
  logic [ID_BITS-1:0] nxt_d      [LEVELS];
  logic [ID_BITS-1:0] nxt_eff    [LEVELS];

  // Outstanding refill read
  logic          pend_q, pend_d;
  logic [LW-1:0] pend_lvl_q, pend_lvl_d;

  // Result register
  logic             done_q;
  mpf_pkg::result_t res_q, res_d;

  // RAM port
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ID_BITS-1:0] ram_wdata, ram_rdata;

  // Decode of the registered item
  logic [4:0]         act_cnt;
  logic [LEVELS-1:0]  act_msk;
  logic               pri_ok;
  logic [LW-1:0]      req_lvl;
  logic [ID_BITS-1:0] task_w;
  logic               is_push, is_pop;
  logic               top_pre_vld;
  logic [LW-1:0]      top_pre;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = res_q;

  // Out-of-range register values clamp to 1..LEVELS.
  always_comb begin
    if (act_q == 4'd0) begin
      act_cnt = 5'd1;
    end else if ({1'b0, act_q} > 5'(LEVELS)) begin
      act_cnt = 5'(LEVELS);
    end else begin
      act_cnt = {1'b0, act_q};
    end
  end

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      act_msk[i] = 5'(i) < act_cnt;
    end
  end

  assign pri_ok  = (in_q.priority_req != 4'd0) && ({1'b0, in_q.priority_req} <= act_cnt);
  assign req_lvl = LW'(in_q.priority_req - 4'd1);
  assign task_w  = ID_BITS'(in_q.task_id);
  assign is_push = in_vld_q && (in_q.mode == mpf_pkg::MODE_PUSH);
  assign is_pop  = in_vld_q && (in_q.mode == mpf_pkg::MODE_POP);

  // Highest nonempty active level before the step (pop target).
  always_comb begin
    top_pre_vld = 1'b0;
    top_pre     = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (act_msk[i] && (fill_q[i] != '0)) begin
        top_pre_vld = 1'b1;
        top_pre     = LW'(i);
      end
    end
  end

  // Refill data bypasses the second-entry register in the cycle it lands.
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nxt_eff[i] = (pend_q && (pend_lvl_q == LW'(i))) ? ram_rdata : nxt_q[i];
    end
  end

  // Queue update
  mpf_pkg::status_e status;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      head_ptr_d[i] = head_ptr_q[i];
      tail_ptr_d[i] = tail_ptr_q[i];
      fill_d[i]     = fill_q[i];
      head_d[i]     = head_q[i];
      nxt_d[i]      = nxt_eff[i];
    end
    pend_d     = 1'b0;
    pend_lvl_d = pend_lvl_q;
    ram_we     = 1'b0;
    ram_waddr  = addr_of(req_lvl, tail_ptr_q[req_lvl]);
    ram_wdata  = task_w;
    ram_re     = 1'b0;
    ram_raddr  = addr_of(top_pre, ptr_inc(ptr_inc(head_ptr_q[top_pre])));
    status     = pri_ok ? mpf_pkg::STATUS_OK : mpf_pkg::STATUS_BAD_PRI;

    if (is_push) begin
      if (!pri_ok) begin
        status = mpf_pkg::STATUS_BAD_PRI;
      end else if (fill_q[req_lvl] >= FW'(LEVEL_DEPTH)) begin
        status = mpf_pkg::STATUS_FULL;
      end else begin
        ram_we              = 1'b1;
        tail_ptr_d[req_lvl] = ptr_inc(tail_ptr_q[req_lvl]);
        fill_d[req_lvl]     = FW'(fill_q[req_lvl] + 1'b1);
        if (fill_q[req_lvl] == '0) begin
          head_d[req_lvl] = task_w;
        end
        if (fill_q[req_lvl] == FW'(1)) begin
          nxt_d[req_lvl] = task_w;
        end
      end
    end else if (is_pop) begin
      if (!top_pre_vld) begin
        status = mpf_pkg::STATUS_EMPTY;
      end else begin
        head_ptr_d[top_pre] = ptr_inc(head_ptr_q[top_pre]);
        fill_d[top_pre]     = FW'(fill_q[top_pre] - 1'b1);
        if (fill_q[top_pre] >= FW'(2)) begin
          head_d[top_pre] = nxt_eff[top_pre];
        end
        // Fetch the entry that becomes second in line.
        if (fill_q[top_pre] >= FW'(3)) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_lvl_d = top_pre;
        end
      end
    end
  end

  // Result after the step
  always_comb begin
    logic              top_vld;
    logic [LW-1:0]     top_post;
    logic [SUMW-1:0]   sum;
    top_vld  = 1'b0;
    top_post = '0;
    sum      = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (act_msk[i]) begin
        sum = SUMW'(sum + SUMW'(fill_d[i]));
        if (fill_d[i] != '0) begin
          top_vld  = 1'b1;
          top_post = LW'(i);
        end
      end
    end
    res_d.status        = status;
    res_d.head_valid    = top_vld;
    res_d.head_task     = top_vld ? 16'(head_d[top_post]) : 16'd0;
    res_d.head_priority = top_vld ? 4'(4'(top_post) + 4'd1) : 4'd0;
    res_d.total_count   = 8'(sum);
    res_d.level_count   = pri_ok ? 5'(fill_d[req_lvl]) : 5'd0;
  end

  mpf_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(DEPTH)
  ) u_mpf_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= mpf_pkg::ACT_LEVELS_RESET;
      in_vld_q   <= 1'b0;
      done_q     <= 1'b0;
      pend_q     <= 1'b0;
      pend_lvl_q <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_ptr_q[i] <= '0;
        tail_ptr_q[i] <= '0;
        fill_q[i]     <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        act_q <= cfg_data_i;
      end
      in_vld_q   <= start && !busy;
      done_q     <= in_vld_q;
      pend_q     <= pend_d;
      pend_lvl_q <= pend_lvl_d;
      for (int i = 0; i < LEVELS; i++) begin
        head_ptr_q[i] <= head_ptr_d[i];
        tail_ptr_q[i] <= tail_ptr_d[i];
        fill_q[i]     <= fill_d[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
    for (int i = 0; i < LEVELS; i++) begin
      head_q[i] <= head_d[i];
      nxt_q[i]  <= nxt_d[i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mpf_checker.sv
// Port-level checker for the multilevel priority FIFO, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module mpf_checker (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   start,
  input wire                   busy,
  input wire                   done_o,
  input wire mpf_pkg::result_t result_o
);

  logic acc;
  assign acc = start && !busy;

  // Every transaction yields exactly one result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 done_o)
    else $error("missing result for accepted transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, 2))
    else $error("result without a transaction");

  // An empty queue reports no head and no tasks.
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.head_valid) |->
      (result_o.head_task == 16'd0 && result_o.head_priority == 4'd0 &&
       result_o.total_count == 8'd0))
    else $error("empty result carries head or count");

  // A pop on empty leaves nothing queued at any active level.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == mpf_pkg::STATUS_EMPTY) |->
      (!result_o.head_valid && result_o.level_count == 5'd0))
    else $error("pop on empty with tasks queued");

endmodule

bind multilevel_priority_fifo_core mpf_checker u_mpf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .result_o(result_o)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the multilevel strict priority FIFO core.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int N_LEVELS    = 8;
  localparam int LVL_DEPTH   = 16;
  localparam int PHASE_ITEMS = 240;
  // Mode code 3 is not in the enum; the block treats it as a query.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Predicts the head/count view after every command and checks the
  // core's results against it, in order.
  class level_fifo_tracker;
    logic [15:0]      task_store [N_LEVELS][LVL_DEPTH];
    int               rd_ptr   [N_LEVELS];
    int               wr_ptr   [N_LEVELS];
    int               fill     [N_LEVELS];
    logic [3:0]       levels_reg;
    mpf_pkg::result_t predicted_views [$];
    int               mismatches;

    function new();
      for (int l = 0; l < N_LEVELS; l++) begin
        rd_ptr[l] = 0;
        wr_ptr[l] = 0;
        fill[l]   = 0;
      end
      levels_reg = mpf_pkg::ACT_LEVELS_RESET;
      mismatches = 0;
    endfunction

    function int active_count();
      if (levels_reg == 4'd0) return 1;
      if (levels_reg > N_LEVELS) return N_LEVELS;
      return int'(levels_reg);
    endfunction

    function void set_levels(logic [3:0] value);
      levels_reg = value;
    endfunction

    function int outstanding();
      return predicted_views.size();
    endfunction

    // Highest nonempty level within the active range, -1 when none.
    function int top_level();
      for (int l = active_count() - 1; l >= 0; l--)
        if (fill[l] != 0) return l;
      return -1;
    endfunction

    // Applies one accepted command and queues the view the core must report.
    function void apply_command(mpf_pkg::item_t cmd);
      mpf_pkg::result_t view;
      int      act;
      int      top;
      int      lvl;
      int      sum;
      bit      pri_ok;
      act    = active_count();
      pri_ok = (cmd.priority_req >= 4'd1) && (int'(cmd.priority_req) <= act);
      view   = '0;
      view.status = mpf_pkg::STATUS_OK;
      if (cmd.mode == mpf_pkg::MODE_PUSH) begin
        if (!pri_ok) begin
          view.status = mpf_pkg::STATUS_BAD_PRI;
        end else begin
          lvl = int'(cmd.priority_req) - 1;
          if (fill[lvl] >= LVL_DEPTH) begin
            view.status = mpf_pkg::STATUS_FULL;
          end else begin
            task_store[lvl][wr_ptr[lvl]] = cmd.task_id;
            wr_ptr[lvl] = (wr_ptr[lvl] + 1) % LVL_DEPTH;
            fill[lvl]++;
          end
        end
      end else if (cmd.mode == mpf_pkg::MODE_POP) begin
        top = top_level();
        if (top < 0) begin
          view.status = mpf_pkg::STATUS_EMPTY;
        end else begin
          rd_ptr[top] = (rd_ptr[top] + 1) % LVL_DEPTH;
          fill[top]--;
          view.status = pri_ok ? mpf_pkg::STATUS_OK : mpf_pkg::STATUS_BAD_PRI;
        end
      end else begin
        view.status = pri_ok ? mpf_pkg::STATUS_OK : mpf_pkg::STATUS_BAD_PRI;
      end
      top = top_level();
      sum = 0;
      for (int l = 0; l < act; l++) sum += fill[l];
      if (top >= 0) begin
        view.head_valid    = 1'b1;
        view.head_task     = task_store[top][rd_ptr[top]];
        view.head_priority = 4'(top + 1);
      end
      view.total_count = 8'(sum);
      view.level_count = pri_ok ? 5'(fill[int'(cmd.priority_req) - 1]) : 5'd0;
      predicted_views.push_back(view);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(mpf_pkg::result_t got);
      mpf_pkg::result_t want;
      if (predicted_views.size() == 0) begin
        report_mismatch("result with no command outstanding");
        return;
      end
      want = predicted_views.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.head_valid !== want.head_valid)
        report_mismatch($sformatf("head_valid got %0b want %0b",
                                  got.head_valid, want.head_valid));
      if (got.head_task !== want.head_task)
        report_mismatch($sformatf("head_task got %h want %h",
                                  got.head_task, want.head_task));
      if (got.head_priority !== want.head_priority)
        report_mismatch($sformatf("head_priority got %0d want %0d",
                                  got.head_priority, want.head_priority));
      if (got.total_count !== want.total_count)
        report_mismatch($sformatf("total_count got %0d want %0d",
                                  got.total_count, want.total_count));
      if (got.level_count !== want.level_count)
        report_mismatch($sformatf("level_count got %0d want %0d",
                                  got.level_count, want.level_count));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  mpf_pkg::item_t   item_i;
  logic             done_o;
  mpf_pkg::result_t result_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [3:0]       cfg_data_i;

  level_fifo_tracker tracker;

  multilevel_priority_fifo_core #(
    .LEVELS      (N_LEVELS),
    .LEVEL_DEPTH (LVL_DEPTH),
    .ID_BITS     (16)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result monitor: done_o/result_o are sampled at the edge that ends the
  // strobe cycle. The receiver cannot stall, so every strobe is a transaction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(result_o);
  end

  // Hard stop in case the core hangs or stops producing results.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Inputs change at the falling edge. A command is a transaction at the
  // rising edge where start is high and busy is low; the tracker is updated
  // right there so predictions follow acceptance order. start is left high
  // so back-to-back commands need no extra assignment.
  task automatic send_command(mpf_pkg::item_t cmd, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= cmd;
    do @(posedge clk_i); while (busy);
    tracker.apply_command(cmd);
  endtask

  // Drops start and waits until every predicted result has been checked.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  // Register write: only issued once the core is drained.
  task automatic write_levels(logic [3:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_levels(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic mpf_pkg::item_t make_command(logic [1:0] mode, logic [15:0] id,
                                                  logic [3:0] pri);
    mpf_pkg::item_t cmd;
    cmd.mode         = mode;
    cmd.task_id      = id;
    cmd.priority_req = pri;
    return cmd;
  endfunction

  // Random command. push_pct steers the push/pop mix so levels both fill up
  // and run dry; hot_level concentrates pushes so single levels hit full.
  function automatic mpf_pkg::item_t random_command(int push_pct, int hot_level);
    mpf_pkg::item_t cmd;
    int    act;
    int    r;
    int    pri;
    act = tracker.active_count();
    r   = $urandom_range(99);
    if (r < 4)
      cmd.mode = MODE_SPARE;
    else if (r < 12)
      cmd.mode = mpf_pkg::MODE_QUERY;
    else if ($urandom_range(99) < push_pct)
      cmd.mode = mpf_pkg::MODE_PUSH;
    else
      cmd.mode = mpf_pkg::MODE_POP;
    r = $urandom_range(99);
    if (r < 10) begin
      // Out-of-range level: 0 or anything above the active count.
      do pri = $urandom_range(15); while (pri >= 1 && pri <= act);
    end else if (r < 50) begin
      pri = hot_level;
    end else begin
      pri = $urandom_range(act, 1);
    end
    cmd.priority_req = 4'(pri);
    cmd.task_id      = 16'($urandom);
    return cmd;
  endfunction

  // Level settings per phase: reset value, the minimum, zero (acts as one),
  // all-ones (acts as eight), and some in between so hidden levels come back.
  logic [3:0] phase_levels [8] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd2, 4'd8};
  // Sender idle percentage per phase, cycling: none, heavy, none, light.
  int         phase_idle   [4] = '{0, 49, 0, 18};
  int         mix_choices  [3] = '{15, 50, 85};

  initial begin
    int push_pct;
    int hot_level;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    tracker     = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty queue, bad levels on every mode, extreme ids and
    // levels, the spare mode code, strict priority order, and a full level.
    send_command(make_command(mpf_pkg::MODE_QUERY, 16'h0000, 4'd0), 0);
    send_command(make_command(mpf_pkg::MODE_POP,   16'h0000, 4'd1), 0);
    send_command(make_command(mpf_pkg::MODE_POP,   16'hFFFF, 4'd0), 0);
    send_command(make_command(mpf_pkg::MODE_PUSH,  16'h1234, 4'd0), 0);
    send_command(make_command(mpf_pkg::MODE_PUSH,  16'h5678, 4'd9), 0);
    send_command(make_command(mpf_pkg::MODE_PUSH,  16'hFFFF, 4'd15), 0);
    send_command(make_command(mpf_pkg::MODE_PUSH,  16'h0000, 4'd1), 0);
    send_command(make_command(mpf_pkg::MODE_PUSH,  16'hFFFF, 4'd8), 0);
    send_command(make_command(MODE_SPARE,          16'hA5A5, 4'd8), 0);
    send_command(make_command(mpf_pkg::MODE_QUERY, 16'h0000, 4'd15), 0);
    send_command(make_command(mpf_pkg::MODE_POP,   16'h0000, 4'd0), 0);
    for (int i = 0; i < LVL_DEPTH + 1; i++)
      send_command(make_command(mpf_pkg::MODE_PUSH, 16'(16'hC000 + i), 4'd4), 0);
    send_command(make_command(mpf_pkg::MODE_POP,   16'h0000, 4'd4), 0);
    send_command(make_command(mpf_pkg::MODE_POP,   16'h0000, 4'd1), 0);
    drain_results();

    // Random phases, each behind a register write on a drained core.
    for (int p = 0; p < 8; p++) begin
      write_levels(phase_levels[p]);
      push_pct  = 50;
      hot_level = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          push_pct  = mix_choices[$urandom_range(2)];
          hot_level = $urandom_range(tracker.active_count(), 1);
        end
        // In every third phase, from the second on, the sender holds off mid-phase until every result is back.
        if (n == PHASE_ITEMS / 2 && p % 3 == 1) drain_results();
        send_command(random_command(push_pct, hot_level), phase_idle[p % 4]);
      end
      drain_results();
    end

    // Short settle so a stray late strobe would still be caught.
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
